// ===== rtl/credtab_pkg.sv =====
package credtab_pkg;

  // Field widths of the channel words
  localparam int unsigned OP_W    = 3;
  localparam int unsigned SLOT_FW = 5;
  localparam int unsigned FID_W   = 16;
  localparam int unsigned ST_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLONE    = 3'd0,
    OP_DROP     = 3'd1,
    OP_QUERY    = 3'd2,
    OP_SET_UID  = 3'd3,
    OP_SET_EUID = 3'd4,
    OP_SET_GID  = 3'd5,
    OP_SET_EGID = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_DENIED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_ROOT    = 3'd4
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the input word and start the table read
    logic commit;  // write back the table and load the result register
  } credtab_cmd_t;

endpackage

// ===== rtl/credtab_if.sv =====
interface credtab_in_if;
  import credtab_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [SLOT_FW-1:0]   slot;
  logic [FID_W-1:0]     new_id;

  modport source (output valid, operation, slot, new_id, input ready);
  modport sink   (input valid, operation, slot, new_id, output ready);
endinterface

interface credtab_out_if;
  import credtab_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [SLOT_FW-1:0]   result_slot;
  logic [FID_W-1:0]     user_id;
  logic [FID_W-1:0]     group_id;
  logic [FID_W-1:0]     eff_user_id;
  logic [FID_W-1:0]     eff_group_id;
  logic                 superuser;

  modport source (output valid, status, result_slot, user_id, group_id, eff_user_id,
                  eff_group_id, superuser, input ready);
  modport sink   (input valid, status, result_slot, user_id, group_id, eff_user_id,
                  eff_group_id, superuser, output ready);
endinterface

// ===== rtl/credtab_ctrl.sv =====
module credtab_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output credtab_pkg::credtab_cmd_t  cmd
);
  import credtab_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = commit;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/credtab_dp.sv =====
module credtab_dp #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned ID_BITS       = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  credtab_pkg::credtab_cmd_t          cmd,
  input  logic [credtab_pkg::OP_W-1:0]       in_operation,
  input  logic [credtab_pkg::SLOT_FW-1:0]    in_slot,
  input  logic [credtab_pkg::FID_W-1:0]      in_new_id,
  output logic [credtab_pkg::ST_W-1:0]       out_status,
  output logic [credtab_pkg::SLOT_FW-1:0]    out_result_slot,
  output logic [credtab_pkg::FID_W-1:0]      out_user_id,
  output logic [credtab_pkg::FID_W-1:0]      out_group_id,
  output logic [credtab_pkg::FID_W-1:0]      out_eff_user_id,
  output logic [credtab_pkg::FID_W-1:0]      out_eff_group_id,
  output logic                               out_superuser
);
  import credtab_pkg::*;

  localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);

  typedef struct packed {
    logic [ID_BITS-1:0] ru;
    logic [ID_BITS-1:0] rg;
    logic [ID_BITS-1:0] eu;
    logic [ID_BITS-1:0] eg;
    logic [ID_BITS-1:0] su;
    logic [ID_BITS-1:0] sg;
  } ent_t;

  ent_t cred_mem [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                     root_wr_r;
  logic [ID_BITS-1:0]       root_uid_r;
  ent_t                     rd_r;
  logic                     rd_zero_r;
  op_t                      op_r;
  logic [SLOT_FW-1:0]       slot_r;
  logic [SLOT_W-1:0]        idx_r;
  logic [ID_BITS-1:0]       v_r;
  logic                     ok_r;
  logic [SLOT_W-1:0]        free_idx_r, free_idx_nxt;
  logic                     free_any_r, free_any_nxt;

  logic [ST_W-1:0]          status_r;
  logic [SLOT_FW-1:0]       result_slot_r;
  logic [FID_W-1:0]         user_id_r;
  logic [FID_W-1:0]         group_id_r;
  logic [FID_W-1:0]         eff_user_id_r;
  logic [FID_W-1:0]         eff_group_id_r;
  logic                     superuser_r;

  logic [SLOT_W-1:0]  in_idx;
  logic               in_ok;
  ent_t               cur, upd;
  logic               su_cur, su_new, show, wr;
  logic [SLOT_W-1:0]  waddr;
  logic               set_valid, clr_valid;
  logic [ID_BITS-1:0] ref_uid;
  status_t            status;
  logic [SLOT_FW-1:0] res_slot;

  assign in_idx = SLOT_W'(in_slot);
  assign in_ok  = (in_operation <= OP_SET_EGID) &&
                  (32'(in_slot) < 32'(TABLE_ENTRIES)) && valid_r[in_idx];

  // lowest free slot, refreshed every cycle from the valid bits
  always_comb begin
    free_idx_nxt = '0;
    free_any_nxt = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx_nxt = SLOT_W'(i);
        free_any_nxt = 1'b1;
      end
    end
  end

  // slot 0 reads as all zero until first written
  assign cur    = rd_zero_r ? '0 : rd_r;
  assign su_cur = (cur.ru == root_uid_r) || (cur.eu == root_uid_r);

  always_comb begin
    status    = ST_OK;
    upd       = cur;
    show      = 1'b1;
    wr        = 1'b0;
    waddr     = idx_r;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    res_slot  = slot_r;
    if (!ok_r) begin
      status = ST_INVALID;
      show   = 1'b0;
    end else begin
      case (op_r)
        OP_CLONE: begin
          if (free_any_r) begin
            wr        = 1'b1;
            set_valid = 1'b1;
            waddr     = free_idx_r;
            res_slot  = SLOT_FW'(free_idx_r);
          end else begin
            status = ST_FULL;
            show   = 1'b0;
          end
        end
        OP_DROP: begin
          if (idx_r == '0) begin
            status = ST_ROOT;
          end else begin
            clr_valid = 1'b1;
            show      = 1'b0;
          end
        end
        OP_QUERY: ;
        OP_SET_UID: begin
          if (su_cur) begin
            upd.ru = v_r; upd.eu = v_r; upd.su = v_r; wr = 1'b1;
          end else if (cur.ru == v_r || cur.su == v_r) begin
            upd.eu = v_r; wr = 1'b1;
          end else begin
            status = ST_DENIED;
          end
        end
        OP_SET_EUID: begin
          if (su_cur || cur.eu == v_r) begin
            upd.eu = v_r; wr = 1'b1;
          end else begin
            status = ST_DENIED;
          end
        end
        OP_SET_GID: begin
          if (su_cur) begin
            upd.rg = v_r; upd.eg = v_r; upd.sg = v_r; wr = 1'b1;
          end else if (cur.rg == v_r || cur.sg == v_r) begin
            upd.eg = v_r; wr = 1'b1;
          end else begin
            status = ST_DENIED;
          end
        end
        default: begin
          if (su_cur || cur.eg == v_r) begin
            upd.eg = v_r; wr = 1'b1;
          end else begin
            status = ST_DENIED;
          end
        end
      endcase
    end
  end

  // a change to root's real uid moves the reference at once
  assign ref_uid = (waddr == '0) ? upd.ru : root_uid_r;
  assign su_new  = show && ((upd.ru == ref_uid) || (upd.eu == ref_uid));

  assign out_status       = status_r;
  assign out_result_slot  = result_slot_r;
  assign out_user_id      = user_id_r;
  assign out_group_id     = group_id_r;
  assign out_eff_user_id  = eff_user_id_r;
  assign out_eff_group_id = eff_group_id_r;
  assign out_superuser    = superuser_r;

  always_ff @(posedge clk) begin
    if (cmd.commit && wr) cred_mem[waddr] <= upd;
    if (cmd.load) rd_r <= cred_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_t'(in_operation);
      slot_r    <= in_slot;
      idx_r     <= in_idx;
      v_r       <= ID_BITS'(in_new_id);
      ok_r      <= in_ok;
      rd_zero_r <= (in_idx == '0) && !root_wr_r;
    end
    free_idx_r <= free_idx_nxt;
    free_any_r <= free_any_nxt;
    if (cmd.commit) begin
      status_r       <= status;
      result_slot_r  <= res_slot;
      user_id_r      <= show ? FID_W'(upd.ru) : '0;
      group_id_r     <= show ? FID_W'(upd.rg) : '0;
      eff_user_id_r  <= show ? FID_W'(upd.eu) : '0;
      eff_group_id_r <= show ? FID_W'(upd.eg) : '0;
      superuser_r    <= su_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= TABLE_ENTRIES'(1);
      root_wr_r  <= 1'b0;
      root_uid_r <= '0;
    end else if (cmd.commit) begin
      if (set_valid) valid_r[waddr] <= 1'b1;
      if (clr_valid) valid_r[waddr] <= 1'b0;
      if (wr && waddr == '0) begin
        root_wr_r  <= 1'b1;
        root_uid_r <= upd.ru;
      end
    end
  end

endmodule

// ===== rtl/credential_table_with_setid_rules_top.sv =====
// Credential table with set-ID rules. Holds TABLE_ENTRIES slots, each with a
// valid bit and real, effective and saved user and group IDs of ID_BITS bits;
// slot 0 is root, valid from reset with all IDs zero, and cannot be dropped.
// Each input word carries an operation (clone, drop, query, set uid/euid/
// gid/egid), a slot and a new ID, and yields exactly one result word with a
// status, the result slot, the slot's IDs after the operation and its
// superuser flag (real or effective uid equal to root's current real uid).
// The block takes no new word until the previous one is written back. The
// first step reads the target entry from the single-port credential memory
// into a register; the second applies the rules, writes back and loads the
// result register. A new word is taken while the previous result still
// waits on out_ch; the write-back stalls only when that result has not yet
// been taken. No clearing pass is needed after reset: valid bits live in
// flip-flops and root's entry reads as zero until first written.
module credential_table_with_setid_rules_top #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned ID_BITS       = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  credtab_in_if.sink    in_ch,
  credtab_out_if.source out_ch
);
  import credtab_pkg::*;

  credtab_cmd_t cmd;

  // sequencing: accept, then write back when the result register is free
  credtab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // table, rule evaluation and result register
  credtab_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ID_BITS       (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_ch.operation),
    .in_slot          (in_ch.slot),
    .in_new_id        (in_ch.new_id),
    .out_status       (out_ch.status),
    .out_result_slot  (out_ch.result_slot),
    .out_user_id      (out_ch.user_id),
    .out_group_id     (out_ch.group_id),
    .out_eff_user_id  (out_ch.eff_user_id),
    .out_eff_group_id (out_ch.eff_group_id),
    .out_superuser    (out_ch.superuser)
  );

endmodule

// ===== sim/tb_credential_table_with_setid_rules_top.sv =====
`timescale 1ns / 100ps

module tb_credential_table_with_setid_rules_top;
  import credtab_pkg::*;

  // Operation code 7 is outside the defined set and must come back as invalid
  localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;
  localparam int unsigned     QUIET_LIMIT = 4000;
  localparam int unsigned     RANDOM_WORDS = 830;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [SLOT_FW-1:0] result_slot;
    logic [FID_W-1:0]   user_id;
    logic [FID_W-1:0]   group_id;
    logic [FID_W-1:0]   eff_user_id;
    logic [FID_W-1:0]   eff_group_id;
    logic               superuser;
  } cred_word_t;

  // Shadow of the credential table: applies each accepted request word and
  // queues the reply word the block owes for it.
  class credential_shadow;
    localparam int N = 32;
    bit               in_use [N];
    logic [FID_W-1:0] ruid [N];
    logic [FID_W-1:0] rgid [N];
    logic [FID_W-1:0] euid [N];
    logic [FID_W-1:0] egid [N];
    logic [FID_W-1:0] suid [N];
    logic [FID_W-1:0] sgid [N];
    cred_word_t       owed_replies [$];
    int               errors;

    function new();
      errors = 0;
      for (int i = 0; i < N; i++) begin
        in_use[i] = 1'b0;
        ruid[i] = '0; rgid[i] = '0; euid[i] = '0;
        egid[i] = '0; suid[i] = '0; sgid[i] = '0;
      end
      in_use[0] = 1'b1;
    endfunction

    function bit root_match(int s);
      return ruid[s] == ruid[0] || euid[s] == ruid[0];
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    // Queue the reply for slot s; hide the IDs where the status says so
    function void owe(status_t st, int s, bit show);
      cred_word_t w;
      w = '0;
      w.status      = st;
      w.result_slot = s[SLOT_FW-1:0];
      if (show) begin
        w.user_id      = ruid[s];
        w.group_id     = rgid[s];
        w.eff_user_id  = euid[s];
        w.eff_group_id = egid[s];
        w.superuser    = in_use[s] && root_match(s);
      end
      owed_replies.push_back(w);
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [SLOT_FW-1:0] slot,
                            logic [FID_W-1:0] id);
      int      s;
      int      fresh;
      bit      su;
      status_t st;
      s = slot;
      if (op > OP_SET_EGID || s >= N || !in_use[s]) begin
        owe(ST_INVALID, s, 1'b0);
        return;
      end
      if (op == OP_CLONE) begin
        fresh = -1;
        for (int i = 0; i < N; i++)
          if (!in_use[i] && fresh < 0) fresh = i;
        if (fresh < 0) begin
          owe(ST_FULL, s, 1'b0);
        end else begin
          in_use[fresh] = 1'b1;
          ruid[fresh] = ruid[s]; rgid[fresh] = rgid[s];
          euid[fresh] = euid[s]; egid[fresh] = egid[s];
          suid[fresh] = suid[s]; sgid[fresh] = sgid[s];
          owe(ST_OK, fresh, 1'b1);
        end
        return;
      end
      if (op == OP_DROP) begin
        if (s == 0) begin
          owe(ST_ROOT, s, 1'b1);
        end else begin
          in_use[s] = 1'b0;
          ruid[s] = '0; rgid[s] = '0; euid[s] = '0;
          egid[s] = '0; suid[s] = '0; sgid[s] = '0;
          owe(ST_OK, s, 1'b0);
        end
        return;
      end
      // Query falls through with nothing to change
      su = root_match(s);
      st = ST_OK;
      case (op)
        OP_SET_UID: begin
          if (su) begin
            ruid[s] = id; euid[s] = id; suid[s] = id;
          end else if (ruid[s] == id || suid[s] == id) begin
            euid[s] = id;
          end else begin
            st = ST_DENIED;
          end
        end
        OP_SET_EUID: begin
          if (su || euid[s] == id) euid[s] = id;
          else st = ST_DENIED;
        end
        OP_SET_GID: begin
          if (su) begin
            rgid[s] = id; egid[s] = id; sgid[s] = id;
          end else if (rgid[s] == id || sgid[s] == id) begin
            egid[s] = id;
          end else begin
            st = ST_DENIED;
          end
        end
        OP_SET_EGID: begin
          if (su || egid[s] == id) egid[s] = id;
          else st = ST_DENIED;
        end
        default: ;
      endcase
      owe(st, s, 1'b1);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_word(cred_word_t got);
      cred_word_t want;
      if (owed_replies.size() == 0) begin
        report($sformatf("reply for slot %0d with nothing owed", got.result_slot));
        return;
      end
      want = owed_replies.pop_front();
      compare_field("status",       got.status,       want.status);
      compare_field("result_slot",  got.result_slot,  want.result_slot);
      compare_field("user_id",      got.user_id,      want.user_id);
      compare_field("group_id",     got.group_id,     want.group_id);
      compare_field("eff_user_id",  got.eff_user_id,  want.eff_user_id);
      compare_field("eff_group_id", got.eff_group_id, want.eff_group_id);
      compare_field("superuser",    got.superuser,    want.superuser);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  credtab_in_if  in_ch ();
  credtab_out_if out_ch ();

  credential_table_with_setid_rules_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  credential_shadow shadow = new();

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold    = 0;   // cycles the receiver still has to hold off
  int mix_kind   = 0;   // 0 grow the table, 1 shrink it, 2 even mix
  int quiet_cycles = 0;

  // Receiver: pick ready at the falling edge. A pending hold-off wins over
  // the random stalls; it lets the block fill up and push back on its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_idle_on && $urandom_range(99) < 29) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Sample replies at the rising edge, where the handshake completes
  always @(posedge clk) begin
    cred_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status       = out_ch.status;
      got.result_slot  = out_ch.result_slot;
      got.user_id      = out_ch.user_id;
      got.group_id     = out_ch.group_id;
      got.eff_user_id  = out_ch.eff_user_id;
      got.eff_group_id = out_ch.eff_group_id;
      got.superuser    = out_ch.superuser;
      shadow.check_word(got);
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_credential_table_with_setid_rules_top: errors");
      $finish;
    end
  end

  // Offer one request word from a falling edge and hold it until taken.
  // Random idle cycles go in front of the word; valid stays high otherwise.
  task automatic send_word(logic [OP_W-1:0] op, logic [SLOT_FW-1:0] slot,
                           logic [FID_W-1:0] id);
    while (tx_idle_on && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.slot      <= slot;
    in_ch.new_id    <= id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    shadow.note_word(op, slot, id);
    @(negedge clk);
  endtask

  // Build a random request. Most words target a live slot and carry an ID
  // that the permission rules can accept, so that set paths really succeed.
  task automatic pick_word(output logic [OP_W-1:0] op, output logic [SLOT_FW-1:0] slot,
                           output logic [FID_W-1:0] id);
    int live [$];
    int r;
    int s;
    int clone_cut;
    int drop_cut;
    for (int i = 0; i < 32; i++)
      if (shadow.in_use[i]) live.push_back(i);
    case (mix_kind)
      0:       begin clone_cut = 55; drop_cut = 60; end
      1:       begin clone_cut = 10; drop_cut = 55; end
      default: begin clone_cut = 25; drop_cut = 45; end
    endcase
    r = $urandom_range(99);
    if (r < 2)              op = OP_UNKNOWN;
    else if (r < clone_cut) op = OP_CLONE;
    else if (r < drop_cut)  op = OP_DROP;
    else if (r < drop_cut + 8) op = OP_QUERY;
    else op = OP_W'(OP_SET_UID + $urandom_range(3));

    if ($urandom_range(99) < 88) s = live[$urandom_range(live.size() - 1)];
    else s = $urandom_range(31);
    slot = s[SLOT_FW-1:0];

    r = $urandom_range(99);
    if (r < 30) begin
      // reuse one of the slot's own IDs of the matching kind
      if (op == OP_SET_GID || op == OP_SET_EGID)
        case ($urandom_range(2))
          0:       id = shadow.rgid[s];
          1:       id = shadow.sgid[s];
          default: id = shadow.egid[s];
        endcase
      else
        case ($urandom_range(2))
          0:       id = shadow.ruid[s];
          1:       id = shadow.suid[s];
          default: id = shadow.euid[s];
        endcase
    end else if (r < 42) begin
      id = shadow.ruid[0];
    end else if (r < 50) begin
      id = $urandom_range(1) ? '1 : '0;
    end else begin
      id = FID_W'($urandom_range(16'hFFFF));
    end
  endtask

  initial begin
    logic [OP_W-1:0]    op;
    logic [SLOT_FW-1:0] slot;
    logic [FID_W-1:0]   id;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.slot      = '0;
    in_ch.new_id    = '0;
    out_ch.ready    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: root queries, invalid and unknown requests, then the
    // permission rules from both sides of the superuser test.
    send_word(OP_QUERY,    5'd0,  16'h0000);
    send_word(OP_DROP,     5'd0,  16'h0000);   // root cannot be dropped
    send_word(OP_QUERY,    5'd31, 16'hFFFF);   // slot never allocated
    send_word(OP_UNKNOWN,  5'd0,  16'h1234);
    send_word(OP_CLONE,    5'd31, 16'h0000);   // clone from a free slot
    send_word(OP_CLONE,    5'd0,  16'h0000);   // takes slot 1
    send_word(OP_SET_UID,  5'd1,  16'hFFFF);   // still superuser: sets all three
    send_word(OP_SET_EUID, 5'd1,  16'h0000);   // no longer superuser: denied
    send_word(OP_SET_UID,  5'd1,  16'hFFFF);   // matches real uid
    send_word(OP_SET_GID,  5'd1,  16'hA5A5);   // denied
    send_word(OP_SET_GID,  5'd1,  16'h0000);   // matches real gid
    send_word(OP_SET_EGID, 5'd1,  16'h0000);
    send_word(OP_SET_EGID, 5'd1,  16'h5A5A);   // denied
    send_word(OP_CLONE,    5'd1,  16'h0000);   // copy of slot 1 into slot 2
    send_word(OP_SET_UID,  5'd0,  16'hFFFF);   // move the superuser reference
    send_word(OP_QUERY,    5'd2,  16'h0000);   // now superuser through root
    send_word(OP_SET_GID,  5'd2,  16'h1234);
    send_word(OP_SET_EUID, 5'd2,  16'h4321);
    send_word(OP_SET_UID,  5'd0,  16'h0000);
    send_word(OP_DROP,     5'd2,  16'h0000);
    send_word(OP_DROP,     5'd2,  16'h0000);   // already free
    send_word(OP_SET_EGID, 5'd0,  16'hFFFF);
    send_word(OP_DROP,     5'd1,  16'h0000);

    // Random part in epochs of differing mix; the first one fills the table
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) mix_kind = (n == 0) ? 0 : $urandom_range(2);
      // a long calm stretch with neither side idling
      tx_idle_on = !(n >= 500 && n < 650);
      rx_idle_on = tx_idle_on;
      if (n == 200) rx_hold = 300;
      if (n == 420) begin
        // hold the sender back until every reply is home
        in_ch.valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge clk);
        @(negedge clk);
      end
      pick_word(op, slot, id);
      send_word(op, slot, id);
    end
    in_ch.valid <= 1'b0;

    // Drain, then wait for any stray reply before the final check
    while (shadow.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (shadow.pending() != 0)
      shadow.report($sformatf("%0d replies never arrived", shadow.pending()));

    if (shadow.errors == 0)
      $display("tb_credential_table_with_setid_rules_top: clean");
    else
      $display("tb_credential_table_with_setid_rules_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/credtab_pkg.sv
rtl/credtab_if.sv
rtl/credtab_ctrl.sv
rtl/credtab_dp.sv
rtl/credential_table_with_setid_rules_top.sv
sim/tb_credential_table_with_setid_rules_top.sv
